// ===== rtl/dif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dif_pkg: shared definitions for the delta integrate one-pole filter
// Widths, register indexes, defaults and the configuration bundle.
// ----------------------------------------------------------------------------
package dif_pkg;

   localparam int DATA_W              = 32;
   localparam int LEVEL_W             = 64;
   localparam int FRAC_BITS           = 16;
   localparam int SHIFT_W             = 6;
   localparam int MIX_W               = 2;
   localparam int CSR_IDX_W           = 2;
   localparam int CSR_DATA_W          = 6;
   localparam int INTEGRATE_SHIFT_DEF = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRATE_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWPASS_SHIFT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHPASS_SHIFT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_COUNT        = 2'd3;

   // Mix count codes; the unused top code behaves as two inputs.
   localparam logic [MIX_W-1:0] MIX_NONE = 2'd0;
   localparam logic [MIX_W-1:0] MIX_ONE  = 2'd1;
   localparam logic [MIX_W-1:0] MIX_TWO  = 2'd2;
   localparam logic [MIX_W-1:0] MIX_ALL  = 2'd3;

   typedef struct packed {
      logic               integrate_enable;
      logic [SHIFT_W-1:0] lowpass_shift;
      logic [SHIFT_W-1:0] highpass_shift;
      logic [MIX_W-1:0]   mix_count;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/dif_integrator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dif_integrator: optional delta integrator
// Wrapping 32-bit accumulator, scaled down by an arithmetic right shift.
// ----------------------------------------------------------------------------
module dif_integrator #(
   parameter int INTEGRATE_SHIFT = dif_pkg::INTEGRATE_SHIFT_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          load,
   input  wire                          integrate_enable,
   input  wire  [dif_pkg::DATA_W-1:0]   sample,
   output logic [dif_pkg::DATA_W-1:0]   x_out
);

   logic [dif_pkg::DATA_W-1:0] acc_ff;
   logic [dif_pkg::DATA_W-1:0] acc_in;

   assign acc_in = acc_ff + sample;

   always_comb begin
      if (integrate_enable) begin
         x_out = $unsigned($signed(acc_in) >>> INTEGRATE_SHIFT);
      end else begin
         x_out = sample;
      end
   end

   // The accumulator holds while integration is off.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (load && integrate_enable) begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dif_one_pole.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dif_one_pole: one-pole level tracker
// Level moves toward the scaled input by the difference shifted right.
// ----------------------------------------------------------------------------
module dif_one_pole (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          load,
   input  wire  [dif_pkg::SHIFT_W-1:0]  shift,
   input  wire  [dif_pkg::DATA_W-1:0]   x_in,
   output logic [dif_pkg::DATA_W-1:0]   level_word
);

   localparam int EXT_W = dif_pkg::LEVEL_W - dif_pkg::DATA_W - dif_pkg::FRAC_BITS;

   logic [dif_pkg::LEVEL_W-1:0] level_ff;
   logic [dif_pkg::LEVEL_W-1:0] level_in;
   logic [dif_pkg::LEVEL_W-1:0] scaled;
   logic [dif_pkg::LEVEL_W-1:0] diff;

   // Sign-extend the input and place it above the fraction bits.
   assign scaled   = {{EXT_W{x_in[dif_pkg::DATA_W-1]}}, x_in, {dif_pkg::FRAC_BITS{1'b0}}};
   assign diff     = scaled - level_ff;
   assign level_in = level_ff + $unsigned($signed(diff) >>> shift);

   // Integer part of the updated level, low 32 bits.
   assign level_word = level_in[dif_pkg::FRAC_BITS +: dif_pkg::DATA_W];

   // A zero shift bypasses the stage and the level holds.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (load && (shift != '0)) begin
         level_ff <= level_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dif_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dif_mixer: extra mix inputs
// Adds up to two extra samples with 32-bit wraparound.
// ----------------------------------------------------------------------------
module dif_mixer (
   input  wire  [dif_pkg::MIX_W-1:0]   mix_count,
   input  wire  [dif_pkg::DATA_W-1:0]  x_in,
   input  wire  [dif_pkg::DATA_W-1:0]  mix_a,
   input  wire  [dif_pkg::DATA_W-1:0]  mix_b,
   output logic [dif_pkg::DATA_W-1:0]  sum
);

   always_comb begin
      case (mix_count) inside
         dif_pkg::MIX_NONE: sum = x_in;
         dif_pkg::MIX_ONE:  sum = x_in + mix_a;
         dif_pkg::MIX_TWO,
         dif_pkg::MIX_ALL:  sum = x_in + mix_a + mix_b;
         default:           sum = x_in;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/delta_integrate_onepole_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A request accepted into stage 1 moves through stages 2, 3 and 4 to the output
// register, whose valid bit drives rsp_valid.
// Throughput: one request per cycle while the output is not stalled; each filter
// level is updated by one subtract, shift and add.
// Reset (synchronous, active high) clears the integrator, both filter levels,
// all configuration registers and every pipeline valid bit.
// ----------------------------------------------------------------------------
// delta_integrate_onepole_filter: integrating one-pole lowpass/highpass
// Optional delta integration, lowpass, highpass and mixing in a short
// elastic pipeline: an input stage, then one stage per function.
// ----------------------------------------------------------------------------
module delta_integrate_onepole_filter #(
   parameter int INTEGRATE_SHIFT = dif_pkg::INTEGRATE_SHIFT_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // Request channel.
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  signed [dif_pkg::DATA_W-1:0]   req_sample_in,
   input  wire  signed [dif_pkg::DATA_W-1:0]   req_mix_a,
   input  wire  signed [dif_pkg::DATA_W-1:0]   req_mix_b,
   // Result channel.
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [dif_pkg::DATA_W-1:0]   rsp_sample_out,
   // Configuration write port.
   input  wire                                 csr_write_enable,
   input  wire  [dif_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [dif_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int W = dif_pkg::DATA_W;

   // Configuration registers. They must be written only while the pipeline is empty, so
   // that every stage can read them directly; the user must keep to this, as the block does not enforce it.
   dif_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dif_pkg::CSR_INTEGRATE_ENABLE: cfg_ff.integrate_enable <= csr_data[0];
            dif_pkg::CSR_LOWPASS_SHIFT:
               cfg_ff.lowpass_shift <= csr_data[dif_pkg::SHIFT_W-1:0];
            dif_pkg::CSR_HIGHPASS_SHIFT:
               cfg_ff.highpass_shift <= csr_data[dif_pkg::SHIFT_W-1:0];
            dif_pkg::CSR_MIX_COUNT:
               cfg_ff.mix_count <= csr_data[dif_pkg::MIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline stages:
   //   stage 1 holds the accepted request,
   //   stage 2 holds the integrator result,
   //   stage 3 holds the lowpass result,
   //   stage 4 holds the highpass result,
   //   stage 5 is the output register with the mix inputs added.
   // Each stage loads when it is empty or when the stage after it moves on,
   // so bubbles close up and a stalled result does not block the request side
   // while an earlier stage is still empty.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic load1, load2, load3, load4, load5;

   assign rdy5 = !v5_ff || rsp_ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign load1 = req_valid && rdy1;
   assign load2 = v1_ff && rdy2;
   assign load3 = v2_ff && rdy3;
   assign load4 = v3_ff && rdy4;
   assign load5 = v4_ff && rdy5;

   assign req_ready = rdy1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // Payload registers; the mix samples travel along with the request.
   logic [W-1:0] s1_sample_ff, s1_mix_a_ff, s1_mix_b_ff;
   logic [W-1:0] s2_x_ff, s2_mix_a_ff, s2_mix_b_ff;
   logic [W-1:0] s3_x_ff, s3_mix_a_ff, s3_mix_b_ff;
   logic [W-1:0] s4_x_ff, s4_mix_a_ff, s4_mix_b_ff;
   logic [W-1:0] s5_out_ff;

   logic [W-1:0] s2_x_in;
   logic [W-1:0] lp_word;
   logic [W-1:0] hp_word;
   logic [W-1:0] s3_x_in;
   logic [W-1:0] s4_x_in;
   logic [W-1:0] s5_out_in;

   // Integrator: the accumulator advances with each request that leaves
   // stage 1 while integration is enabled.
   dif_integrator #(
      .INTEGRATE_SHIFT (INTEGRATE_SHIFT)
   ) u_integrator (
      .clock            (clock),
      .reset            (reset),
      .load             (load2),
      .integrate_enable (cfg_ff.integrate_enable),
      .sample           (s1_sample_ff),
      .x_out            (s2_x_in)
   );

   // Lowpass: the output is the integer part of the new level; a zero shift passes the sample through.
   dif_one_pole u_lowpass (
      .clock      (clock),
      .reset      (reset),
      .load       (load3),
      .shift      (cfg_ff.lowpass_shift),
      .x_in       (s2_x_ff),
      .level_word (lp_word)
   );

   assign s3_x_in = (cfg_ff.lowpass_shift != '0) ? lp_word : s2_x_ff;

   // Highpass: the tracked level is subtracted from the sample. A zero shift
   // passes the sample through unchanged.
   dif_one_pole u_highpass (
      .clock      (clock),
      .reset      (reset),
      .load       (load4),
      .shift      (cfg_ff.highpass_shift),
      .x_in       (s3_x_ff),
      .level_word (hp_word)
   );

   assign s4_x_in = (cfg_ff.highpass_shift != '0) ? (s3_x_ff - hp_word) : s3_x_ff;

   dif_mixer u_mixer (
      .mix_count (cfg_ff.mix_count),
      .x_in      (s4_x_ff),
      .mix_a     (s4_mix_a_ff),
      .mix_b     (s4_mix_b_ff),
      .sum       (s5_out_in)
   );

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_sample_ff <= $unsigned(req_sample_in);
         s1_mix_a_ff  <= $unsigned(req_mix_a);
         s1_mix_b_ff  <= $unsigned(req_mix_b);
      end
      if (load2) begin
         s2_x_ff     <= s2_x_in;
         s2_mix_a_ff <= s1_mix_a_ff;
         s2_mix_b_ff <= s1_mix_b_ff;
      end
      if (load3) begin
         s3_x_ff     <= s3_x_in;
         s3_mix_a_ff <= s2_mix_a_ff;
         s3_mix_b_ff <= s2_mix_b_ff;
      end
      if (load4) begin
         s4_x_ff     <= s4_x_in;
         s4_mix_a_ff <= s3_mix_a_ff;
         s4_mix_b_ff <= s3_mix_b_ff;
      end
      if (load5) begin
         s5_out_ff <= s5_out_in;
      end
   end

   assign rsp_sample_out = $signed(s5_out_ff);

endmodule
`default_nettype wire
